FILE: sv/ssd_pkg.sv
// Shared types and constants for the step/direction generator.
// Op, command, status and register codes plus parameter defaults.
// No dependencies.
package ssd_pkg;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF     = 8;
    localparam int STEP_COUNT_BITS_DEF = 24;
    localparam int PERIOD_BITS_DEF     = 16;

    // Configuration port geometry and register widths
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 1;
    localparam int HOME_PERIOD_W = 16;
    localparam int HOME_STEPS_W  = 24;

    localparam logic [HOME_PERIOD_W-1:0] HOME_PERIOD_RST = 16'd625;
    localparam logic [HOME_STEPS_W-1:0]  HOME_MAX_RST    = 24'd320000;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_MOVE    = 3'd1,
        OP_HOME    = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_MOVE    = 3'd2,
        CMD_HOME    = 3'd3,
        CMD_ENABLE  = 3'd4,
        CMD_DISABLE = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NONE         = 3'd0,
        ST_ACCEPTED     = 3'd1,
        ST_QUEUE_FULL   = 3'd2,
        ST_BUSY         = 3'd3,
        ST_HOME_REACHED = 3'd4,
        ST_HOME_ABORTED = 3'd5,
        ST_ALREADY_HOME = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOME_PERIOD = 1'b0,
        REG_HOME_MAX    = 1'b1
    } t_cfg_reg;

    // Pin levels and status of one result beat
    typedef struct packed {
        logic    step;
        logic    dir;
        logic    enable_n;
        logic    idle;
        t_status status;
    } t_flags;

endpackage

FILE: sv/ssd_front.sv
// Front end: decodes each input beat into a command, precomputes the half period
// and holds the commands in a two-entry queue for the engine.
// Depends on ssd_pkg.
module ssd_front #(
    parameter int SB = ssd_pkg::STEP_COUNT_BITS_DEF,
    parameter int PB = ssd_pkg::PERIOD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_op,
    input  logic              i_move_up,
    input  logic [SB-1:0]     i_step_total,
    input  logic [PB-1:0]     i_period_us,
    input  logic              i_endstop_hit,
    output logic              o_valid,
    input  logic              i_take,
    output ssd_pkg::t_cmd     o_cmd,
    output logic              o_up,
    output logic [SB-1:0]     o_steps,
    output logic [PB-2:0]     o_half,
    output logic              o_hit
);
    localparam int HQ = PB - 1;

    ssd_pkg::t_cmd w_cmd;
    logic [HQ-1:0] w_half;
    logic          w_push;
    logic          w_pop;

    ssd_pkg::t_cmd r_q_cmd   [2];
    logic          r_q_up    [2];
    logic [SB-1:0] r_q_steps [2];
    logic [HQ-1:0] r_q_half  [2];
    logic          r_q_hit   [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;

    // Classify the op
    always_comb begin
        unique case (ssd_pkg::t_op'(i_op))
            ssd_pkg::OP_TICK:    w_cmd = ssd_pkg::CMD_TICK;
            ssd_pkg::OP_MOVE:    w_cmd = ssd_pkg::CMD_MOVE;
            ssd_pkg::OP_HOME:    w_cmd = ssd_pkg::CMD_HOME;
            ssd_pkg::OP_ENABLE:  w_cmd = ssd_pkg::CMD_ENABLE;
            ssd_pkg::OP_DISABLE: w_cmd = ssd_pkg::CMD_DISABLE;
            default:             w_cmd = ssd_pkg::CMD_NONE;
        endcase
    end

    // Halve the period, clamp a zero half period to one tick
    assign w_half = (i_period_us[PB-1:1] == '0) ? HQ'(1) : i_period_us[PB-1:1];

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = o_valid && i_take;

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_cmd[r_wr_ptr]   <= w_cmd;
            r_q_up[r_wr_ptr]    <= i_move_up;
            r_q_steps[r_wr_ptr] <= i_step_total;
            r_q_half[r_wr_ptr]  <= w_half;
            r_q_hit[r_wr_ptr]   <= i_endstop_hit;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assign o_cmd   = r_q_cmd[r_rd_ptr];
    assign o_up    = r_q_up[r_rd_ptr];
    assign o_steps = r_q_steps[r_rd_ptr];
    assign o_half  = r_q_half[r_rd_ptr];
    assign o_hit   = r_q_hit[r_rd_ptr];

endmodule

FILE: sv/ssd_engine.sv
// Back end: move queue, step timing and homing sequencer; one command per cycle
// while the result queue has space. Holds the homing registers and produces one
// result beat per command. Depends on ssd_pkg.
module ssd_engine #(
    parameter int QD = ssd_pkg::QUEUE_DEPTH_DEF,
    parameter int SB = ssd_pkg::STEP_COUNT_BITS_DEF,
    parameter int PB = ssd_pkg::PERIOD_BITS_DEF,
    localparam int CW = $clog2(QD + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_take,
    input  ssd_pkg::t_cmd                 i_cmd,
    input  logic                          i_up,
    input  logic [SB-1:0]                 i_steps,
    input  logic [PB-2:0]                 i_half,
    input  logic                          i_hit,
    input  logic                          i_space,
    output ssd_pkg::t_flags               o_flags,
    output logic [CW-1:0]                 o_level
);
    localparam int QW = (QD > 1) ? $clog2(QD) : 1;
    localparam int HQ = PB - 1;
    localparam int HW = ((PB > ssd_pkg::HOME_PERIOD_W) ? PB : ssd_pkg::HOME_PERIOD_W) - 1;
    localparam int EW = 1 + SB + HQ;
    localparam int HP = ssd_pkg::HOME_PERIOD_W;
    localparam int HS = ssd_pkg::HOME_STEPS_W;

    // Homing registers
    logic [HP-1:0] r_home_period;
    logic [HS-1:0] r_home_max;

    // Move queue
    logic [EW-1:0] r_mem [QD];
    logic [EW-1:0] r_rd;
    logic [QW-1:0] r_head,  n_head;
    logic [CW-1:0] r_count, n_count;

    // Stepper state
    logic          r_moving, n_moving;
    logic          r_homing, n_homing;
    logic [SB-1:0] r_sl,     n_sl;
    logic [HW-1:0] r_half,   n_half;
    logic [HW-1:0] r_pt,     n_pt;
    logic [HS-1:0] r_done,   n_done;
    logic          r_step,   n_step;
    logic          r_dir,    n_dir;
    logic          r_drv,    n_drv;

    logic             w_fire;
    logic             w_wr;
    logic             w_check;
    ssd_pkg::t_status w_status;
    logic [CW:0]      w_sum;
    logic [CW:0]      w_slot_full;
    logic [QW-1:0]    w_slot;
    logic [QW-1:0]    w_head_inc;
    logic [EW-1:0]    w_entry;
    logic             w_rd_up;
    logic [SB-1:0]    w_rd_steps;
    logic [HQ-1:0]    w_rd_half;
    logic [HP-2:0]    w_home_half;
    logic [HW-1:0]    w_pt_dec;
    logic [SB-1:0]    w_sl_dec;

    assign o_take = i_valid && i_space;
    assign w_fire = o_take;

    // Ring addressing
    assign w_sum       = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign w_slot_full = (w_sum >= (CW+1)'(QD)) ? w_sum - (CW+1)'(QD) : w_sum;
    assign w_slot      = w_slot_full[QW-1:0];
    assign w_head_inc  = (r_head == QW'(QD - 1)) ? '0 : r_head + 1'b1;

    assign w_entry    = {i_up, i_steps, i_half};
    assign w_rd_up    = r_rd[EW-1];
    assign w_rd_steps = r_rd[SB+HQ-1:HQ];
    assign w_rd_half  = r_rd[HQ-1:0];

    assign w_home_half = (r_home_period[HP-1:1] == '0) ? (HP-1)'(1) : r_home_period[HP-1:1];
    assign w_pt_dec    = r_pt - 1'b1;
    assign w_sl_dec    = (r_sl != '0) ? r_sl - 1'b1 : '0;

    // Next state for the command at the head of the front queue
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_moving = r_moving;
        n_homing = r_homing;
        n_sl     = r_sl;
        n_half   = r_half;
        n_pt     = r_pt;
        n_done   = r_done;
        n_step   = r_step;
        n_dir    = r_dir;
        n_drv    = r_drv;
        w_wr     = 1'b0;
        w_check  = 1'b0;
        w_status = ssd_pkg::ST_NONE;

        if (w_fire) begin
            unique case (i_cmd)
                ssd_pkg::CMD_TICK: begin
                    if (r_homing) begin
                        // Low phase over: check endstop before the next step
                        if (r_pt == '0) begin
                            w_check = 1'b1;
                        end else if (w_pt_dec != '0) begin
                            n_pt = w_pt_dec;
                        end else if (r_step) begin
                            n_step = 1'b0;
                            n_pt   = r_half;
                        end else begin
                            w_check = 1'b1;
                        end
                    end else if (r_moving) begin
                        if (r_pt > HW'(1)) begin
                            n_pt = w_pt_dec;
                        end else begin
                            n_pt = '0;
                            if (r_step) begin
                                n_step = 1'b0;
                                n_pt   = r_half;
                            end else begin
                                n_sl = w_sl_dec;
                                if (w_sl_dec != '0) begin
                                    n_step = 1'b1;
                                    n_pt   = r_half;
                                end else begin
                                    n_moving = 1'b0;
                                end
                            end
                        end
                    end else if (r_count != '0) begin
                        // Start the oldest queued move
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                        n_dir   = w_rd_up;
                        n_sl    = w_rd_steps;
                        n_half  = HW'(w_rd_half);
                        if (w_rd_steps != '0) begin
                            n_moving = 1'b1;
                            n_step   = 1'b1;
                            n_pt     = HW'(w_rd_half);
                        end
                    end
                end
                ssd_pkg::CMD_MOVE: begin
                    if (r_count == CW'(QD)) begin
                        w_status = ssd_pkg::ST_QUEUE_FULL;
                    end else begin
                        w_wr     = 1'b1;
                        n_count  = r_count + 1'b1;
                        w_status = ssd_pkg::ST_ACCEPTED;
                    end
                end
                ssd_pkg::CMD_HOME: begin
                    if (r_moving || r_homing || r_count != '0) begin
                        w_status = ssd_pkg::ST_BUSY;
                    end else if (i_hit) begin
                        w_status = ssd_pkg::ST_ALREADY_HOME;
                    end else begin
                        n_drv    = 1'b1;
                        n_dir    = 1'b0;
                        n_homing = 1'b1;
                        n_done   = '0;
                        n_step   = 1'b0;
                        n_pt     = '0;
                        n_half   = HW'(w_home_half);
                        w_status = ssd_pkg::ST_ACCEPTED;
                    end
                end
                ssd_pkg::CMD_ENABLE: begin
                    n_drv    = 1'b1;
                    w_status = ssd_pkg::ST_ACCEPTED;
                end
                ssd_pkg::CMD_DISABLE: begin
                    n_drv    = 1'b0;
                    w_status = ssd_pkg::ST_ACCEPTED;
                end
                default: ;
            endcase

            // Homing endstop check and step start
            if (w_check) begin
                if (i_hit) begin
                    n_homing = 1'b0;
                    n_step   = 1'b0;
                    n_pt     = '0;
                    w_status = ssd_pkg::ST_HOME_REACHED;
                end else if (r_done >= r_home_max) begin
                    n_homing = 1'b0;
                    n_step   = 1'b0;
                    n_pt     = '0;
                    w_status = ssd_pkg::ST_HOME_ABORTED;
                end else begin
                    n_done = r_done + 1'b1;
                    n_step = 1'b1;
                    n_pt   = r_half;
                end
            end
        end
    end

    // Result beat reflects the state after the command
    always_comb begin
        o_flags.step     = n_step;
        o_flags.dir      = n_dir;
        o_flags.enable_n = ~n_drv;
        o_flags.idle     = !n_moving && !n_homing && (n_count == '0);
        o_flags.status   = w_status;
        o_level          = n_count;
    end

    // Queue storage, read data registered at the next head, same-slot write forwarded
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_slot] <= w_entry;
        r_rd <= (w_wr && w_slot == n_head) ? w_entry : r_mem[n_head];
    end

    // Homing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_period <= ssd_pkg::HOME_PERIOD_RST;
            r_home_max    <= ssd_pkg::HOME_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (ssd_pkg::t_cfg_reg'(i_cfg_idx))
                ssd_pkg::REG_HOME_PERIOD: r_home_period <= i_cfg_data[HP-1:0];
                ssd_pkg::REG_HOME_MAX:    r_home_max    <= i_cfg_data[HS-1:0];
                default: ;
            endcase
        end
    end

    // Stepper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_moving <= 1'b0;
            r_homing <= 1'b0;
            r_sl     <= '0;
            r_half   <= '0;
            r_pt     <= '0;
            r_done   <= '0;
            r_step   <= 1'b0;
            r_dir    <= 1'b0;
            r_drv    <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_moving <= n_moving;
            r_homing <= n_homing;
            r_sl     <= n_sl;
            r_half   <= n_half;
            r_pt     <= n_pt;
            r_done   <= n_done;
            r_step   <= n_step;
            r_dir    <= n_dir;
            r_drv    <= n_drv;
        end
    end

endmodule

FILE: sv/ssd_result_q.sv
// Two-entry result queue between the engine and the result ports.
// Generic width; no package dependency.
module ssd_result_q #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_space,
    input  logic [W-1:0] i_data,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_q [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_q[r_rd_ptr];

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr_ptr] <= i_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

FILE: sv/stepper_step_dir_generator.sv
// Step/direction pulse generator top level: front decoder, stepping engine, result queue.
// Depends on ssd_pkg, ssd_front, ssd_engine, ssd_result_q.
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------------
//  input     | push / full      | i_op i_move_up i_step_total i_period_us i_endstop_hit
//  result    | pop / empty      | o_step_line o_dir_line o_enable_n o_idle o_status
//            |                  | o_queue_level
//  config    | i_cfg_we         | i_cfg_idx i_cfg_data
//
// One beat per cycle in and out while neither full nor empty stalls it; every input
// beat yields one result beat. A beat's result reaches the result ports through the
// front command register and the result queue register around the engine.
// Reset is synchronous; the move queue storage is not cleared.
// A stalled result side fills the result queue, then the front queue, then raises full.
module stepper_step_dir_generator #(
    parameter int QUEUE_DEPTH     = ssd_pkg::QUEUE_DEPTH_DEF,
    parameter int STEP_COUNT_BITS = ssd_pkg::STEP_COUNT_BITS_DEF,
    parameter int PERIOD_BITS     = ssd_pkg::PERIOD_BITS_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    i_op,
    input  logic                          i_move_up,
    input  logic [STEP_COUNT_BITS-1:0]    i_step_total,
    input  logic [PERIOD_BITS-1:0]        i_period_us,
    input  logic                          i_endstop_hit,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_step_line,
    output logic                          o_dir_line,
    output logic                          o_enable_n,
    output logic                          o_idle,
    output logic [2:0]                    o_status,
    output logic [CW-1:0]                 o_queue_level
);
    localparam int FW = $bits(ssd_pkg::t_flags);
    localparam int RW = FW + CW;

    logic                       w_cmd_valid;
    logic                       w_take;
    ssd_pkg::t_cmd              w_cmd;
    logic                       w_up;
    logic [STEP_COUNT_BITS-1:0] w_steps;
    logic [PERIOD_BITS-2:0]     w_half;
    logic                       w_hit;
    logic                       w_space;
    ssd_pkg::t_flags            w_flags;
    logic [CW-1:0]              w_level;
    logic [RW-1:0]              w_res_data;
    ssd_pkg::t_flags            w_out_flags;

    // Decode and buffer input beats
    ssd_front #(
        .SB (STEP_COUNT_BITS),
        .PB (PERIOD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_move_up     (i_move_up),
        .i_step_total  (i_step_total),
        .i_period_us   (i_period_us),
        .i_endstop_hit (i_endstop_hit),
        .o_valid       (w_cmd_valid),
        .i_take        (w_take),
        .o_cmd         (w_cmd),
        .o_up          (w_up),
        .o_steps       (w_steps),
        .o_half        (w_half),
        .o_hit         (w_hit)
    );

    // Execute commands
    ssd_engine #(
        .QD (QUEUE_DEPTH),
        .SB (STEP_COUNT_BITS),
        .PB (PERIOD_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_cmd_valid),
        .o_take     (w_take),
        .i_cmd      (w_cmd),
        .i_up       (w_up),
        .i_steps    (w_steps),
        .i_half     (w_half),
        .i_hit      (w_hit),
        .i_space    (w_space),
        .o_flags    (w_flags),
        .o_level    (w_level)
    );

    // Hold results until popped
    ssd_result_q #(
        .W (RW)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .o_space (w_space),
        .i_data  ({w_flags, w_level}),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (w_res_data)
    );

    assign w_out_flags   = ssd_pkg::t_flags'(w_res_data[RW-1:CW]);
    assign o_step_line   = w_out_flags.step;
    assign o_dir_line    = w_out_flags.dir;
    assign o_enable_n    = w_out_flags.enable_n;
    assign o_idle        = w_out_flags.idle;
    assign o_status      = w_out_flags.status;
    assign o_queue_level = w_res_data[CW-1:0];

endmodule

FILE: bench/stepper_step_dir_generator_chk.sv
// Checker for the step/direction generator: watches the input, result and config beats,
// keeps its own copy of the move queue, stepping engine and registers, and compares results.
// Depends on ssd_pkg.
`timescale 1ns / 100ps
module stepper_step_dir_generator_chk
    import ssd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [2:0]           i_op,
    input  logic                 i_move_up,
    input  logic [23:0]          i_step_total,
    input  logic [15:0]          i_period_us,
    input  logic                 i_endstop_hit,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic                 i_step_line,
    input  logic                 i_dir_line,
    input  logic                 i_enable_n,
    input  logic                 i_idle,
    input  logic [2:0]           i_status,
    input  logic [3:0]           i_queue_level,
    output int                   o_errors = 0,
    output int                   o_pending = 0,
    output logic                 o_model_idle = 1'b1
);

    localparam int MQ_DEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        t_flags     flags;
        logic [3:0] level;
    } t_pin_status;

    // Predicted pin levels and status, oldest first
    t_pin_status pin_status_q[$];

    // Shadow move queue
    logic        mq_up     [MQ_DEPTH];
    logic [23:0] mq_steps  [MQ_DEPTH];
    logic [15:0] mq_period [MQ_DEPTH];
    int          q_head;
    int          q_cnt;

    // Shadow engine and registers
    logic        run_move;
    logic        run_home;
    logic [23:0] steps_rem;
    logic [23:0] home_done;
    logic [14:0] half_per;
    logic [14:0] ph_timer;
    logic        step_lvl;
    logic        dir_lvl;
    logic        drv_on;
    logic [15:0] home_period;
    logic [23:0] home_max;
    int          err_cnt = 0;

    function automatic void clear_engine();
        q_head      = 0;
        q_cnt       = 0;
        run_move    = 1'b0;
        run_home    = 1'b0;
        steps_rem   = '0;
        home_done   = '0;
        half_per    = '0;
        ph_timer    = '0;
        step_lvl    = 1'b0;
        dir_lvl     = 1'b0;
        drv_on      = 1'b0;
        home_period = HOME_PERIOD_RST;
        home_max    = HOME_MAX_RST;
    endfunction

    // Half period in ticks, never below one
    function automatic logic [14:0] clamp_half(input logic [15:0] per);
        logic [14:0] h;
        h = per[15:1];
        return (h == 15'd0) ? 15'd1 : h;
    endfunction

    // Endstop check at the start of a homing step
    function automatic t_status home_probe(input logic hit);
        if (hit || home_done >= home_max) begin
            run_home = 1'b0;
            step_lvl = 1'b0;
            ph_timer = '0;
            if (hit)
                return ST_HOME_REACHED;
            return ST_HOME_ABORTED;
        end
        home_done = home_done + 24'd1;
        step_lvl  = 1'b1;
        ph_timer  = half_per;
        return ST_NONE;
    endfunction

    // One microsecond of engine time
    function automatic t_status tick_engine(input logic hit);
        if (run_home) begin
            if (ph_timer == 15'd0)
                return home_probe(hit);
            ph_timer = ph_timer - 15'd1;
            if (ph_timer != 15'd0)
                return ST_NONE;
            if (step_lvl) begin
                step_lvl = 1'b0;
                ph_timer = half_per;
                return ST_NONE;
            end
            return home_probe(hit);
        end
        if (run_move) begin
            if (ph_timer != 15'd0)
                ph_timer = ph_timer - 15'd1;
            if (ph_timer != 15'd0)
                return ST_NONE;
            if (step_lvl) begin
                step_lvl = 1'b0;
                ph_timer = half_per;
                return ST_NONE;
            end
            if (steps_rem != 24'd0)
                steps_rem = steps_rem - 24'd1;
            if (steps_rem != 24'd0) begin
                step_lvl = 1'b1;
                ph_timer = half_per;
            end else begin
                run_move = 1'b0;
            end
            return ST_NONE;
        end
        // Take the oldest queued move; direction and first step on this tick
        if (q_cnt != 0) begin
            dir_lvl   = mq_up[q_head];
            steps_rem = mq_steps[q_head];
            half_per  = clamp_half(mq_period[q_head]);
            q_head    = (q_head + 1) % MQ_DEPTH;
            q_cnt     = q_cnt - 1;
            if (steps_rem != 24'd0) begin
                run_move = 1'b1;
                step_lvl = 1'b1;
                ph_timer = half_per;
            end
        end
        return ST_NONE;
    endfunction

    function automatic t_pin_status predict_pins(input logic [2:0] op, input logic up,
                                                 input logic [23:0] steps,
                                                 input logic [15:0] per, input logic hit);
        t_status     st;
        t_pin_status r;
        int          slot;
        st = ST_NONE;
        case (op)
            OP_TICK: st = tick_engine(hit);
            OP_MOVE: begin
                if (q_cnt >= MQ_DEPTH) begin
                    st = ST_QUEUE_FULL;
                end else begin
                    slot            = (q_head + q_cnt) % MQ_DEPTH;
                    mq_up[slot]     = up;
                    mq_steps[slot]  = steps;
                    mq_period[slot] = per;
                    q_cnt           = q_cnt + 1;
                    st              = ST_ACCEPTED;
                end
            end
            OP_HOME: begin
                if (run_move || run_home || q_cnt != 0) begin
                    st = ST_BUSY;
                end else if (hit) begin
                    st = ST_ALREADY_HOME;
                end else begin
                    drv_on    = 1'b1;
                    dir_lvl   = 1'b0;
                    run_home  = 1'b1;
                    home_done = '0;
                    step_lvl  = 1'b0;
                    ph_timer  = '0;
                    half_per  = clamp_half(home_period);
                    st        = ST_ACCEPTED;
                end
            end
            OP_ENABLE: begin
                drv_on = 1'b1;
                st     = ST_ACCEPTED;
            end
            OP_DISABLE: begin
                drv_on = 1'b0;
                st     = ST_ACCEPTED;
            end
            default: ;
        endcase
        r.flags.step     = step_lvl;
        r.flags.dir      = dir_lvl;
        r.flags.enable_n = !drv_on;
        r.flags.idle     = !run_move && !run_home && q_cnt == 0;
        r.flags.status   = st;
        r.level          = 4'(q_cnt);
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    initial clear_engine();

    // Compare result beats, follow register writes, predict accepted input beats
    always @(posedge i_clk) begin : watch
        t_pin_status want;
        if (!i_rst_n) begin
            clear_engine();
        end else begin
            if (i_pop && !i_empty) begin
                if (pin_status_q.size() == 0) begin
                    $display("%0t result beat with nothing expected: status %0d", $time,
                             i_status);
                    err_cnt++;
                end else begin
                    want = pin_status_q.pop_front();
                    check_field("step_line", int'(want.flags.step), int'(i_step_line));
                    check_field("dir_line", int'(want.flags.dir), int'(i_dir_line));
                    check_field("enable_n", int'(want.flags.enable_n), int'(i_enable_n));
                    check_field("idle", int'(want.flags.idle), int'(i_idle));
                    check_field("status", int'(want.flags.status), int'(i_status));
                    check_field("queue_level", int'(want.level), int'(i_queue_level));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HOME_PERIOD: home_period = i_cfg_data[HOME_PERIOD_W-1:0];
                    REG_HOME_MAX:    home_max    = i_cfg_data[HOME_STEPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                pin_status_q.push_back(predict_pins(i_op, i_move_up, i_step_total,
                                                    i_period_us, i_endstop_hit));
        end
        o_errors     <= err_cnt;
        o_pending    <= pin_status_q.size();
        o_model_idle <= !run_move && !run_home && q_cnt == 0;
    end

endmodule

FILE: bench/stepper_step_dir_generator_tb.sv
// Testbench top for the step/direction generator: clock, reset, stimulus and verdict.
// Depends on ssd_pkg, stepper_step_dir_generator and stepper_step_dir_generator_chk.
`timescale 1ns / 100ps
module stepper_step_dir_generator_tb;
    import ssd_pkg::*;

    // Op code outside the defined set, ignored by the block
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = REG_HOME_PERIOD;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 push        = 1'b0;
    logic [2:0]           op          = OP_TICK;
    logic                 move_up     = 1'b0;
    logic [23:0]          step_total  = '0;
    logic [15:0]          period_us   = '0;
    logic                 endstop_hit = 1'b0;
    logic                 pop         = 1'b0;

    logic       full;
    logic       empty;
    logic       step_line;
    logic       dir_line;
    logic       enable_n;
    logic       idle;
    logic [2:0] status;
    logic [3:0] queue_level;

    int   errors;
    int   pending;
    logic model_idle;

    // Stimulus controls
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;
    bit long_home  = 1'b1;
    int beats_sent = 0;

    stepper_step_dir_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .push          (push),
        .full          (full),
        .i_op          (op),
        .i_move_up     (move_up),
        .i_step_total  (step_total),
        .i_period_us   (period_us),
        .i_endstop_hit (endstop_hit),
        .empty         (empty),
        .pop           (pop),
        .o_step_line   (step_line),
        .o_dir_line    (dir_line),
        .o_enable_n    (enable_n),
        .o_idle        (idle),
        .o_status      (status),
        .o_queue_level (queue_level)
    );

    stepper_step_dir_generator_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_op          (op),
        .i_move_up     (move_up),
        .i_step_total  (step_total),
        .i_period_us   (period_us),
        .i_endstop_hit (endstop_hit),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_step_line   (step_line),
        .i_dir_line    (dir_line),
        .i_enable_n    (enable_n),
        .i_idle        (idle),
        .i_status      (status),
        .i_queue_level (queue_level),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_model_idle  (model_idle)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // Result side: random pop bursts, one long hold-off, steady pop at the end
    initial begin : drain_results
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                pop <= 1'b0;
                repeat (120) @(posedge i_clk);
                held = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    function automatic logic rnd1();
        return 1'($urandom_range(0, 1));
    endfunction

    // Endstop level for a tick; held triggered when homing steps would be very long
    function automatic logic tick_hit();
        return long_home ? 1'b1 : ($urandom_range(0, 14) == 0);
    endfunction

    // Offer one beat, possibly after an idle burst, and hold it until accepted
    task automatic send_beat(input logic [2:0] b_op, input logic b_up,
                             input logic [23:0] b_steps, input logic [15:0] b_per,
                             input logic b_hit);
        if (!calm && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        push        <= 1'b1;
        op          <= b_op;
        move_up     <= b_up;
        step_total  <= b_steps;
        period_us   <= b_per;
        endstop_hit <= b_hit;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic tick();
        send_beat(OP_TICK, rnd1(), 24'($urandom()), 16'($urandom()), tick_hit());
    endtask

    // Short move: mostly a few steps at a short period
    task automatic small_move();
        logic [23:0] st;
        logic [15:0] pr;
        st = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(4, 8))
                                         : 24'($urandom_range(0, 3));
        pr = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(8, 40))
                                         : 16'($urandom_range(0, 6));
        send_beat(OP_MOVE, rnd1(), st, pr, rnd1());
    endtask

    // Tick until moves, homing and queue are all done
    task automatic run_dry();
        tick();
        tick();
        while (!model_idle) tick();
    endtask

    // Stop offering and wait for every outstanding result beat
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] per, input logic [23:0] mx);
        run_dry();
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_HOME_PERIOD;
        cfg_data <= {8'($urandom()), per};
        @(posedge i_clk);
        cfg_idx  <= REG_HOME_MAX;
        cfg_data <= mx;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        long_home = (per > 16'd64);
    endtask

    // Burst of moves with the odd request mixed in, then some ticks
    task automatic seq_moves();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0: send_beat(rnd1() ? OP_ENABLE : OP_DISABLE, rnd1(), 24'($urandom()),
                             16'($urandom()), rnd1());
                1: send_beat(OP_HOME, rnd1(), 24'($urandom()), 16'($urandom()), rnd1());
                default: small_move();
            endcase
        end
        repeat ($urandom_range(0, 30)) tick();
    endtask

    // Fill the queue with no time passing, then offer arbitrary moves that must bounce
    task automatic seq_fill();
        repeat (8) send_beat(OP_MOVE, rnd1(), 24'($urandom_range(0, 2)),
                             16'($urandom_range(0, 3)), rnd1());
        repeat ($urandom_range(1, 3))
            send_beat(OP_MOVE, rnd1(), 24'($urandom()), 16'($urandom()), rnd1());
        if (rnd1())
            send_beat(OP_HOME, rnd1(), 24'($urandom()), 16'($urandom()), rnd1());
        run_dry();
    endtask

    // Homing from idle, sometimes with a move queued behind it
    task automatic seq_home();
        run_dry();
        send_beat(OP_HOME, rnd1(), 24'($urandom()), 16'($urandom()),
                  $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) == 0)
            small_move();
        run_dry();
    endtask

    // Requests other than moves, unknown ops among them
    task automatic seq_noise();
        int o;
        repeat ($urandom_range(1, 4)) begin
            o = $urandom_range(0, 6);
            if (o >= 1)
                o = o + 1;
            send_beat(3'(o), rnd1(), 24'($urandom()), 16'($urandom()),
                      (o == 0) ? tick_hit() : rnd1());
        end
    endtask

    initial begin : stimulus
        int          phase_end;
        int          pick;
        logic [15:0] per;
        logic [23:0] mx;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests from idle at reset settings
        send_beat(OP_HOME, 1'b0, '0, '0, 1'b1);
        send_beat(OP_ENABLE, 1'b0, '0, '0, 1'b0);
        send_beat(OP_DISABLE, 1'b1, '1, '1, 1'b1);
        send_beat(OP_UNUSED_HI, 1'b1, '1, '1, 1'b1);

        // Zero registers: half period clamps, homing aborts at the first check
        write_regs(16'd0, 24'd0);
        send_beat(OP_HOME, 1'b0, '0, '0, 1'b0);
        send_beat(OP_TICK, 1'b0, '0, '0, 1'b0);

        // Largest registers: endstop already reached at the first check
        write_regs(16'hFFFF, 24'hFFFFFF);
        send_beat(OP_HOME, 1'b1, '1, '1, 1'b0);
        send_beat(OP_TICK, 1'b0, '0, '0, 1'b1);

        // Zero-step move, clamped period, home refused while busy, endstop ignored
        send_beat(OP_MOVE, 1'b1, 24'd0, 16'd5, 1'b0);
        send_beat(OP_MOVE, 1'b0, 24'd1, 16'd0, 1'b1);
        send_beat(OP_MOVE, 1'b1, 24'd2, 16'd1, 1'b0);
        send_beat(OP_HOME, 1'b0, '0, '0, 1'b0);
        run_dry();

        // Full queue rejects the largest move
        repeat (8) send_beat(OP_MOVE, 1'b1, 24'd0, 16'hFFFF, 1'b0);
        send_beat(OP_MOVE, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1);
        run_dry();

        // Smallest registers, then random phases
        write_regs(16'd1, 24'd1);
        send_beat(OP_HOME, 1'b0, '0, '0, 1'b0);
        run_dry();

        while (beats_sent < 1150) begin
            case ($urandom_range(0, 5))
                0:       per = 16'd0;
                1:       per = 16'd1;
                2:       per = 16'hFFFF;
                default: per = 16'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 5))
                0:       mx = 24'd0;
                1:       mx = 24'd1;
                2:       mx = 24'hFFFFFF;
                default: mx = 24'($urandom_range(2, 6));
            endcase
            write_regs(per, mx);
            phase_end = beats_sent + 150;
            while (beats_sent < phase_end && beats_sent < 1150) begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    seq_moves();
                else if (pick < 11)
                    seq_fill();
                else if (pick < 17)
                    seq_home();
                else
                    seq_noise();
                if (beats_sent > 350)
                    hold_req = 1'b1;
                if (beats_sent > 1000)
                    calm = 1'b1;
            end
        end

        // Wait for the last results, then give the verdict
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
